### rtl/core/annular_interfacial_area_top_defines.svh
// annular_interfacial_area_top_defines.svh: assertion macros for the block checkers
// needs clk and rst_n in the scope where a macro is used
`ifndef ANNULAR_INTERFACIAL_AREA_TOP_DEFINES_SVH
`define ANNULAR_INTERFACIAL_AREA_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AIA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aia check failed");

// next-cycle implication, disabled in reset
`define AIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aia check failed");

`endif

### rtl/core/aia_pkg.sv
// aia_pkg.sv: widths, constants and register codes of the interfacial area block
// no dependencies
`default_nettype none

package aia_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = FRAC_BITS + 1;
  localparam int DIAM_W     = 32;
  localparam int GAMMA_W    = FIELD_W + 1;
  localparam int ROOT_W     = FIELD_W;
  localparam int SQX_W      = 2 * ROOT_W;
  // 4 times the 2^(24+16-2F) unit scale
  localparam int SCALE_SH   = 2 + 24 + 16 - 2 * FRAC_BITS;
  localparam int PROD1_W    = GAMMA_W + ROOT_W;
  localparam int NUM_W      = PROD1_W + SCALE_SH;
  localparam int AREA_W     = 33;
  localparam int T_W        = FRAC_BITS;
  localparam int U_W        = FRAC_BITS + 1;
  localparam int PROD2_W    = NUM_W + T_W;
  localparam int HI_W       = PROD2_W - AREA_W;

  localparam logic [AREA_W-1:0]  AREA_MAX = '1;
  localparam logic [FIELD_W-1:0] ONE_FRAC = FIELD_W'(1) << FRAC_BITS;

  localparam logic [FRAC_BITS-1:0] CUTOFF_RST   = 16'd58982;
  localparam logic [DIAM_W-1:0]    MIN_DIAM_RST = 32'd1678;

  localparam int ADDR_W = 3;
  localparam logic REG_CUTOFF   = 1'b0;
  localparam logic REG_MIN_DIAM = 1'b1;

endpackage

`default_nettype wire

### rtl/core/aia_if.sv
// aia_if.sv: valid/ready channel interfaces for cell inputs and results
// depends on aia_pkg
`default_nettype none

interface aia_in_if;
  import aia_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] dispersed_fraction;
  logic [FIELD_W-1:0] continuous_fraction;
  logic [FIELD_W-1:0] normalized_fraction;
  logic [DIAM_W-1:0]  hydraulic_diameter;
  modport source (output valid, dispersed_fraction, continuous_fraction,
                  normalized_fraction, hydraulic_diameter, input ready);
  modport sink   (input valid, dispersed_fraction, continuous_fraction,
                  normalized_fraction, hydraulic_diameter, output ready);
endinterface

interface aia_out_if;
  import aia_pkg::*;
  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] area_density;
  logic              saturated;
  modport source (output valid, area_density, saturated, input ready);
  modport sink   (input valid, area_density, saturated, output ready);
endinterface

`default_nettype wire

### rtl/core/aia_sqrt_cell.sv
// aia_sqrt_cell.sv: one digit of a pipelined integer square root
// standalone, chained by the top level
`default_nettype none

module aia_sqrt_cell #(
  parameter int XW = 34,
  parameter int RW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  output logic          rdy_up,
  output logic          v_out,
  input  logic          rdy_dn,
  input  logic [XW-1:0] x_in,
  input  logic [RW+1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  logic [SW-1:0] side_in,
  output logic [XW-1:0] x_r,
  output logic [RW+1:0] rem_r,
  output logic [RW-1:0] root_r,
  output logic [SW-1:0] side_r
);

  logic          v_r;
  logic          adv;
  logic [RW+3:0] cat;
  logic [RW+3:0] trial;
  logic          ge;
  logic [RW+3:0] diff;

  assign adv    = !v_r || rdy_dn;
  assign rdy_up = adv;
  assign v_out  = v_r;

  // bring in two radicand bits and try the next root bit
  assign cat   = {rem_in, x_in[XW-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge    = cat >= trial;
  assign diff  = cat - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= {x_in[XW-3:0], 2'b00};
      rem_r  <= ge ? diff[RW+1:0] : cat[RW+1:0];
      root_r <= {root_in[RW-2:0], ge};
      side_r <= side_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/aia_div_cell.sv
// aia_div_cell.sv: one quotient bit of a pipelined restoring divider
// standalone, chained by the top level
`default_nettype none

module aia_div_cell #(
  parameter int DW = 32,
  parameter int NW = 45,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  output logic          rdy_up,
  output logic          v_out,
  input  logic          rdy_dn,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] div_in,
  input  logic [NW-1:0] dq_in,
  input  logic [SW-1:0] side_in,
  output logic [DW-1:0] rem_r,
  output logic [DW-1:0] div_r,
  output logic [NW-1:0] dq_r,
  output logic [SW-1:0] side_r
);

  logic        v_r;
  logic        adv;
  logic [DW:0] partial;
  logic [DW:0] diff;
  logic        ge;

  assign adv    = !v_r || rdy_dn;
  assign rdy_up = adv;
  assign v_out  = v_r;

  // shift in the next dividend bit, subtract when it fits
  assign partial = {rem_in, dq_in[NW-1]};
  assign ge      = partial >= {1'b0, div_in};
  assign diff    = partial - {1'b0, div_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= ge ? diff[DW-1:0] : partial[DW-1:0];
      div_r  <= div_in;
      dq_r   <= {dq_in[NW-2:0], ge};
      side_r <= side_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/annular_interfacial_area_top.sv
// Annular interfacial area density, one mesh cell per transfer. Each item passes one entry
// stage, 17 square-root cells, a multiply stage, 45 divider cells for the diameter division, a
// taper multiply stage, 33 divider cells for the taper division and an output register. Every
// cell holds its own item and passes it on when the next one can take it, so one item is
// taken and one result given per cycle unless the output stalls; a stalled output lets bubbles
// in the chain close up before the input is held. Registers: cutoff_fraction at byte 0,
// min_diameter at byte 4; write them only while no item is in flight.
// depends on aia_pkg, aia_if, aia_sqrt_cell, aia_div_cell
`default_nettype none

module annular_interfacial_area_top (
  input  logic                   clk,
  input  logic                   rst_n,
  aia_in_if.sink                 in_ch,
  aia_out_if.source              out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [aia_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import aia_pkg::*;

  localparam int SQ_N  = ROOT_W;
  localparam int D1_N  = NUM_W;
  localparam int D2_N  = AREA_W;
  localparam int SQ_SW = GAMMA_W + FIELD_W + DIAM_W;
  localparam int D2_SW = 4 + AREA_W;

  // configuration registers
  logic [FRAC_BITS-1:0] cutoff_r;
  logic [DIAM_W-1:0]    min_diam_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MIN_DIAM) ? min_diam_r : {16'd0, cutoff_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= CUTOFF_RST;
      min_diam_r <= MIN_DIAM_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CUTOFF) begin
        cutoff_r <= pwdata[FRAC_BITS-1:0];
      end else begin
        min_diam_r <= pwdata;
      end
    end
  end

  // entry stage: fraction sum and clamped diameter
  logic               a_v_r, a_adv, a_rdy_dn;
  logic [GAMMA_W-1:0] a_gamma_r;
  logic [FIELD_W-1:0] a_alpha_r;
  logic [DIAM_W-1:0]  a_dm_r;
  logic [DIAM_W-1:0]  dm_clamp;

  assign a_adv       = !a_v_r || a_rdy_dn;
  assign in_ch.ready = a_adv;
  assign dm_clamp    = (in_ch.hydraulic_diameter < min_diam_r) ? min_diam_r
                                                               : in_ch.hydraulic_diameter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_adv) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_gamma_r <= GAMMA_W'(in_ch.dispersed_fraction) + GAMMA_W'(in_ch.continuous_fraction);
      a_alpha_r <= in_ch.normalized_fraction;
      a_dm_r    <= (dm_clamp == '0) ? DIAM_W'(1) : dm_clamp;
    end
  end

  // square root chain on alpha scaled by one
  logic               sq_v   [0:SQ_N];
  logic               sq_rdy [0:SQ_N];
  logic [SQX_W-1:0]   sq_x   [0:SQ_N];
  logic [ROOT_W+1:0]  sq_rem [0:SQ_N];
  logic [ROOT_W-1:0]  sq_root[0:SQ_N];
  logic [SQ_SW-1:0]   sq_side[0:SQ_N];

  assign sq_v[0]    = a_v_r;
  assign a_rdy_dn   = sq_rdy[0];
  assign sq_x[0]    = {1'b0, a_alpha_r, {FRAC_BITS{1'b0}}};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {a_gamma_r, a_alpha_r, a_dm_r};

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    aia_sqrt_cell #(.XW(SQX_W), .RW(ROOT_W), .SW(SQ_SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (sq_v[i]),
      .rdy_up (sq_rdy[i]),
      .v_out  (sq_v[i+1]),
      .rdy_dn (sq_rdy[i+1]),
      .x_in   (sq_x[i]),
      .rem_in (sq_rem[i]),
      .root_in(sq_root[i]),
      .side_in(sq_side[i]),
      .x_r    (sq_x[i+1]),
      .rem_r  (sq_rem[i+1]),
      .root_r (sq_root[i+1]),
      .side_r (sq_side[i+1])
    );
  end

  // multiply stage: numerator of the diameter division
  logic               m_v_r, m_adv, m_rdy_dn;
  logic [PROD1_W-1:0] m_prod_r;
  logic [FIELD_W-1:0] m_alpha_r;
  logic [DIAM_W-1:0]  m_dm_r;
  logic [GAMMA_W-1:0] sq_gamma;

  assign m_adv             = !m_v_r || m_rdy_dn;
  assign sq_rdy[SQ_N]      = m_adv;
  assign sq_gamma          = sq_side[SQ_N][SQ_SW-1 -: GAMMA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_adv) begin
      m_v_r <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      m_prod_r  <= PROD1_W'(sq_gamma) * PROD1_W'(sq_root[SQ_N]);
      m_alpha_r <= sq_side[SQ_N][DIAM_W +: FIELD_W];
      m_dm_r    <= sq_side[SQ_N][DIAM_W-1:0];
    end
  end

  // divider chain by the clamped diameter
  logic               d1_v   [0:D1_N];
  logic               d1_rdy [0:D1_N];
  logic [DIAM_W-1:0]  d1_rem [0:D1_N];
  logic [DIAM_W-1:0]  d1_div [0:D1_N];
  logic [NUM_W-1:0]   d1_dq  [0:D1_N];
  logic [FIELD_W-1:0] d1_side[0:D1_N];

  assign d1_v[0]    = m_v_r;
  assign m_rdy_dn   = d1_rdy[0];
  assign d1_rem[0]  = '0;
  assign d1_div[0]  = m_dm_r;
  assign d1_dq[0]   = {m_prod_r, {SCALE_SH{1'b0}}};
  assign d1_side[0] = m_alpha_r;

  for (genvar i = 0; i < D1_N; i++) begin : g_d1
    aia_div_cell #(.DW(DIAM_W), .NW(NUM_W), .SW(FIELD_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (d1_v[i]),
      .rdy_up (d1_rdy[i]),
      .v_out  (d1_v[i+1]),
      .rdy_dn (d1_rdy[i+1]),
      .rem_in (d1_rem[i]),
      .div_in (d1_div[i]),
      .dq_in  (d1_dq[i]),
      .side_in(d1_side[i]),
      .rem_r  (d1_rem[i+1]),
      .div_r  (d1_div[i+1]),
      .dq_r   (d1_dq[i+1]),
      .side_r (d1_side[i+1])
    );
  end

  // taper stage: mode flags, clipped base and base times (one - alpha)
  logic               t_v_r, t_adv, t_rdy_dn;
  logic [PROD2_W-1:0] t_prod_r;
  logic               t_tap_r, t_zero_r, t_bsat_r;
  logic [AREA_W-1:0]  t_bclip_r;
  logic [NUM_W-1:0]   base;
  logic [FIELD_W-1:0] d1_alpha;
  logic [FIELD_W-1:0] t_full;
  logic               base_big;

  assign t_adv        = !t_v_r || t_rdy_dn;
  assign d1_rdy[D1_N] = t_adv;
  assign base         = d1_dq[D1_N];
  assign d1_alpha     = d1_side[D1_N];
  assign t_full       = ONE_FRAC - d1_alpha;
  assign base_big     = base > NUM_W'(AREA_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (t_adv) begin
      t_v_r <= d1_v[D1_N];
    end
  end

  always_ff @(posedge clk) begin
    if (t_adv) begin
      t_prod_r  <= PROD2_W'(base) * PROD2_W'(t_full[T_W-1:0]);
      t_tap_r   <= d1_alpha > FIELD_W'(cutoff_r);
      t_zero_r  <= d1_alpha >= ONE_FRAC;
      t_bsat_r  <= base_big;
      t_bclip_r <= base_big ? AREA_MAX : base[AREA_W-1:0];
    end
  end

  // divider chain by (one - cutoff); high part decides overflow up front
  logic              d2_v   [0:D2_N];
  logic              d2_rdy [0:D2_N];
  logic [U_W-1:0]    d2_rem [0:D2_N];
  logic [U_W-1:0]    d2_div [0:D2_N];
  logic [AREA_W-1:0] d2_dq  [0:D2_N];
  logic [D2_SW-1:0]  d2_side[0:D2_N];
  logic [U_W-1:0]    u_den;
  logic [HI_W-1:0]   prod_hi;
  logic              ovf;

  assign u_den      = ONE_FRAC - U_W'(cutoff_r);
  assign prod_hi    = t_prod_r[PROD2_W-1 -: HI_W];
  assign ovf        = prod_hi >= HI_W'(u_den);
  assign d2_v[0]    = t_v_r;
  assign t_rdy_dn   = d2_rdy[0];
  assign d2_rem[0]  = ovf ? '0 : prod_hi[U_W-1:0];
  assign d2_div[0]  = u_den;
  assign d2_dq[0]   = t_prod_r[AREA_W-1:0];
  assign d2_side[0] = {t_tap_r, t_zero_r, ovf, t_bsat_r, t_bclip_r};

  for (genvar i = 0; i < D2_N; i++) begin : g_d2
    aia_div_cell #(.DW(U_W), .NW(AREA_W), .SW(D2_SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (d2_v[i]),
      .rdy_up (d2_rdy[i]),
      .v_out  (d2_v[i+1]),
      .rdy_dn (d2_rdy[i+1]),
      .rem_in (d2_rem[i]),
      .div_in (d2_div[i]),
      .dq_in  (d2_dq[i]),
      .side_in(d2_side[i]),
      .rem_r  (d2_rem[i+1]),
      .div_r  (d2_div[i+1]),
      .dq_r   (d2_dq[i+1]),
      .side_r (d2_side[i+1])
    );
  end

  // output register: pick untapered, tapered, zero or saturated result
  logic              o_v_r, o_adv;
  logic [AREA_W-1:0] o_area_r;
  logic              o_sat_r;
  logic              f_tap, f_zero, f_ovf, f_bsat;
  logic [AREA_W-1:0] f_bclip;
  logic [AREA_W-1:0] area_nxt;
  logic              sat_nxt;

  assign {f_tap, f_zero, f_ovf, f_bsat, f_bclip} = d2_side[D2_N];
  assign o_adv        = !o_v_r || out_ch.ready;
  assign d2_rdy[D2_N] = o_adv;

  always_comb begin
    if (!f_tap) begin
      area_nxt = f_bclip;
      sat_nxt  = f_bsat;
    end else if (f_zero) begin
      area_nxt = '0;
      sat_nxt  = 1'b0;
    end else if (f_ovf) begin
      area_nxt = AREA_MAX;
      sat_nxt  = 1'b1;
    end else begin
      area_nxt = d2_dq[D2_N];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_adv) begin
      o_v_r <= d2_v[D2_N];
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      o_area_r <= area_nxt;
      o_sat_r  <= sat_nxt;
    end
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.area_density = o_area_r;
  assign out_ch.saturated    = o_sat_r;

endmodule

`default_nettype wire

### rtl/core/aia_checker.sv
// aia_checker.sv: port-level checks on the interfacial area block, bound to the top level
// depends on aia_pkg and annular_interfacial_area_top_defines.svh
`default_nettype none
`include "annular_interfacial_area_top_defines.svh"

module aia_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [aia_pkg::AREA_W-1:0]    area_density,
  input wire logic                          saturated,
  input wire logic                          pready
);
  import aia_pkg::*;

  // a clipped result always shows the maximum
  `AIA_ASSERT_SAME(a_sat_max, out_valid && saturated, area_density == AREA_MAX)
  // no result right out of reset
  `AIA_ASSERT_SAME(a_reset_empty, $rose(rst_n), !out_valid)
  // a result not taken holds
  `AIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(area_density))
  // the register port never waits
  `AIA_ASSERT_SAME(a_pready, 1'b1, pready)

endmodule

bind annular_interfacial_area_top aia_checker u_aia_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .area_density(out_ch.area_density),
  .saturated   (out_ch.saturated),
  .pready      (pready)
);

`default_nettype wire
